/* sv/cc3p_pkg.sv */
// Shared types, widths and codes for the circumcircle pipeline.
`default_nettype none

package cc3p_pkg;

   localparam int COORD_BITS = 24;
   localparam int FAR_BITS   = 40;

   localparam int CW    = COORD_BITS;
   localparam int QB    = FAR_BITS;
   localparam int DW    = CW + 1;             // point difference, signed
   localparam int PW    = 2 * DW;             // difference product, signed
   localparam int DTW   = PW + 1;             // determinant, signed
   localparam int SW    = DTW;                // squared length, unsigned
   localparam int SLW   = DW;                 // low slice of squared length
   localparam int SHW   = SW - DW;            // high slice of squared length
   localparam int PLW   = DW + SLW + 1;       // low partial product, signed
   localparam int PHW   = DW + SHW + 1;       // high partial product, signed
   localparam int NPW   = DW + SW + 1;        // full product, signed
   localparam int NXW   = NPW + 1;            // numerator, signed
   localparam int NUMW  = NXW;                // rounded numerator magnitude
   localparam int VW    = DTW + 1;            // twice the determinant magnitude
   localparam int CMPW  = VW + QB;            // divider compare width
   localparam int FXW   = ((QB > CW) ? QB : CW) + 2;  // unsaturated center
   localparam int EW    = FXW + 1;            // offset from second point, signed
   localparam int EMW   = FXW;                // offset magnitude
   localparam int ELW   = EMW / 2;
   localparam int EHW   = EMW - ELW;
   localparam int E2W   = 2 * EMW;            // squared offset
   localparam int SQW   = E2W + 1;            // squared distance
   localparam int ROOTIN = 2 * CW;            // root input when in range
   localparam int RRW   = CW + 3;             // root remainder

   // Smallest squared distance whose rounded root no longer fits CW bits
   localparam logic [SQW-1:0] RLIM = SQW'({{CW{1'b1}}, {(CW-1){1'b0}}, 1'b1});

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_COLLINEAR = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [CW-1:0] first_x;
      logic signed [CW-1:0] first_y;
      logic signed [CW-1:0] second_x;
      logic signed [CW-1:0] second_y;
      logic signed [CW-1:0] third_x;
      logic signed [CW-1:0] third_y;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] center_x;
      logic signed [CW-1:0] center_y;
      logic        [CW-1:0] radius;
      logic        [1:0]    status;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/circumcircle_from_three_points_top.sv */
// Circumcircle of three points: fully pipelined center and radius unit.
`default_nettype none

// Takes one transaction of three signed Q12.12 points per cycle while
// req_ready is high and returns the center and radius of the circle through
// them, in order, one result per transaction. Seven stages form the
// differences, determinant and Cramer numerators with split multipliers, a
// restoring divider retires one quotient bit per stage for the rounded
// center offset (FAR_BITS stages plus a range check), five stages form and
// clamp the center and square its distance to the second point, a
// digit-by-digit square root retires one radius bit per stage (COORD_BITS
// stages plus a range check), and one output register holds the result.
// Collinear points give a zero result with
// status 1; a center or radius outside the Q12.12 range saturates with
// status 2. The whole pipe advances together; a skid register behind the
// output register takes one extra result when rsp_ready is low, so
// req_ready is a register output and does not depend on rsp_ready.

module circumcircle_from_three_points_top
   import cc3p_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef struct packed {
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
      logic signed [CW-1:0] x2;
      logic signed [CW-1:0] y2;
   } front_type;

   typedef struct packed {
      logic [NUMW-1:0] remx;
      logic [NUMW-1:0] remy;
      logic [QB-1:0]   qx;
      logic [QB-1:0]   qy;
      logic [VW-1:0]   v;
      logic            negx;
      logic            negy;
      logic            farx;
      logic            fary;
      logic            coll;
      front_type       side;
   } div_type;

   typedef struct packed {
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic                 csat;
      logic                 near;
      logic                 coll;
   } back_type;

   typedef struct packed {
      logic [ROOTIN-1:0] rad;
      logic [RRW-1:0]    rem;
      logic [CW-1:0]     root;
      logic              rsat;
      back_type          bk;
   } sq_type;

   localparam logic signed [FXW-1:0] FX_MAX = $signed({{(FXW-CW+1){1'b0}}, {(CW-1){1'b1}}});
   localparam logic signed [FXW-1:0] FX_MIN = $signed({{(FXW-CW+1){1'b1}}, {(CW-1){1'b0}}});
   localparam logic signed [CW-1:0]  C_MAX  = $signed({1'b0, {(CW-1){1'b1}}});
   localparam logic signed [CW-1:0]  C_MIN  = $signed({1'b1, {(CW-1){1'b0}}});
   localparam logic [CW-1:0]         R_MAX  = {CW{1'b1}};

   logic en;

   // valid bits of every stage
   logic [6:0]  fv_ff;
   logic [QB:0] dvv_ff;
   logic [4:0]  tv_ff;
   logic [CW:0] sqv_ff;

   // ---------------------------------------------------------------
   // Stage 1: differences relative to the first point
   // ---------------------------------------------------------------
   logic signed [DW-1:0] a1_ff, b1_ff, c1_ff, d1_ff;
   front_type            f1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= DW'(req_data.second_x) - DW'(req_data.first_x);
         b1_ff <= DW'(req_data.second_y) - DW'(req_data.first_y);
         c1_ff <= DW'(req_data.third_x) - DW'(req_data.first_x);
         d1_ff <= DW'(req_data.third_y) - DW'(req_data.first_y);
         f1_ff <= '{x1: req_data.first_x, y1: req_data.first_y,
                    x2: req_data.second_x, y2: req_data.second_y};
      end
   end

   // Stage 2: difference products
   logic signed [PW-1:0] ad2_ff, cb2_ff, aa2_ff, bb2_ff, cc2_ff, dd2_ff;
   logic signed [DW-1:0] a2_ff, b2_ff, c2_ff, d2_ff;
   front_type            f2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ad2_ff <= a1_ff * d1_ff;
         cb2_ff <= c1_ff * b1_ff;
         aa2_ff <= a1_ff * a1_ff;
         bb2_ff <= b1_ff * b1_ff;
         cc2_ff <= c1_ff * c1_ff;
         dd2_ff <= d1_ff * d1_ff;
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         c2_ff  <= c1_ff;
         d2_ff  <= d1_ff;
         f2_ff  <= f1_ff;
      end
   end

   // Stage 3: determinant and squared lengths
   logic signed [DTW-1:0] det3_ff;
   logic [SW-1:0]         s23_ff, s33_ff;
   logic signed [DW-1:0]  a3_ff, b3_ff, c3_ff, d3_ff;
   front_type             f3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         det3_ff <= DTW'(ad2_ff) - DTW'(cb2_ff);
         s23_ff  <= SW'(aa2_ff) + SW'(bb2_ff);
         s33_ff  <= SW'(cc2_ff) + SW'(dd2_ff);
         a3_ff   <= a2_ff;
         b3_ff   <= b2_ff;
         c3_ff   <= c2_ff;
         d3_ff   <= d2_ff;
         f3_ff   <= f2_ff;
      end
   end

   // Stage 4: numerator products, split into two slices of the squared length
   logic signed [PLW-1:0] pl_ds2_ff, pl_bs3_ff, pl_as3_ff, pl_cs2_ff;
   logic signed [PHW-1:0] ph_ds2_ff, ph_bs3_ff, ph_as3_ff, ph_cs2_ff;
   logic signed [DTW-1:0] det4_ff;
   front_type             f4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ds2_ff <= d3_ff * $signed({1'b0, s23_ff[SLW-1:0]});
         ph_ds2_ff <= d3_ff * $signed({1'b0, s23_ff[SW-1:SLW]});
         pl_bs3_ff <= b3_ff * $signed({1'b0, s33_ff[SLW-1:0]});
         ph_bs3_ff <= b3_ff * $signed({1'b0, s33_ff[SW-1:SLW]});
         pl_as3_ff <= a3_ff * $signed({1'b0, s33_ff[SLW-1:0]});
         ph_as3_ff <= a3_ff * $signed({1'b0, s33_ff[SW-1:SLW]});
         pl_cs2_ff <= c3_ff * $signed({1'b0, s23_ff[SLW-1:0]});
         ph_cs2_ff <= c3_ff * $signed({1'b0, s23_ff[SW-1:SLW]});
         det4_ff   <= det3_ff;
         f4_ff     <= f3_ff;
      end
   end

   // Stage 5: recombine the slices
   logic signed [NPW-1:0] ds2_5_ff, bs3_5_ff, as3_5_ff, cs2_5_ff;
   logic signed [DTW-1:0] det5_ff;
   front_type             f5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ds2_5_ff <= (NPW'(ph_ds2_ff) <<< SLW) + NPW'(pl_ds2_ff);
         bs3_5_ff <= (NPW'(ph_bs3_ff) <<< SLW) + NPW'(pl_bs3_ff);
         as3_5_ff <= (NPW'(ph_as3_ff) <<< SLW) + NPW'(pl_as3_ff);
         cs2_5_ff <= (NPW'(ph_cs2_ff) <<< SLW) + NPW'(pl_cs2_ff);
         det5_ff  <= det4_ff;
         f5_ff    <= f4_ff;
      end
   end

   // Stage 6: Cramer numerators
   logic signed [NXW-1:0] nx6_ff, ny6_ff;
   logic signed [DTW-1:0] det6_ff;
   front_type             f6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nx6_ff  <= NXW'(ds2_5_ff) - NXW'(bs3_5_ff);
         ny6_ff  <= NXW'(as3_5_ff) - NXW'(cs2_5_ff);
         det6_ff <= det5_ff;
         f6_ff   <= f5_ff;
      end
   end

   // Stage 7: magnitudes, plus half the divisor for round-to-nearest
   logic [NXW-1:0]  absnx_in, absny_in;
   logic [DTW-1:0]  absdet_in;
   logic [NUMW-1:0] numx7_ff, numy7_ff;
   logic [VW-1:0]   v7_ff;
   logic            negx7_ff, negy7_ff, coll7_ff;
   front_type       f7_ff;

   always_comb begin
      absnx_in  = nx6_ff[NXW-1] ? NXW'(-nx6_ff) : NXW'(nx6_ff);
      absny_in  = ny6_ff[NXW-1] ? NXW'(-ny6_ff) : NXW'(ny6_ff);
      absdet_in = det6_ff[DTW-1] ? DTW'(-det6_ff) : DTW'(det6_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         numx7_ff <= NUMW'(absnx_in) + NUMW'(absdet_in);
         numy7_ff <= NUMW'(absny_in) + NUMW'(absdet_in);
         v7_ff    <= {absdet_in, 1'b0};
         negx7_ff <= nx6_ff[NXW-1] ^ det6_ff[DTW-1];
         negy7_ff <= ny6_ff[NXW-1] ^ det6_ff[DTW-1];
         coll7_ff <= (det6_ff == '0);
         f7_ff    <= f6_ff;
      end
   end

   // ---------------------------------------------------------------
   // Divider: range check, then one quotient bit per stage
   // ---------------------------------------------------------------
   div_type         dv_ff [QB+1];
   div_type         dv0_in;
   logic [CMPW-1:0] vfar_in;

   always_comb begin
      vfar_in      = {v7_ff, {QB{1'b0}}};
      dv0_in.remx  = numx7_ff;
      dv0_in.remy  = numy7_ff;
      dv0_in.qx    = '0;
      dv0_in.qy    = '0;
      dv0_in.v     = v7_ff;
      dv0_in.negx  = negx7_ff;
      dv0_in.negy  = negy7_ff;
      dv0_in.farx  = (CMPW'(numx7_ff) >= vfar_in);
      dv0_in.fary  = (CMPW'(numy7_ff) >= vfar_in);
      dv0_in.coll  = coll7_ff;
      dv0_in.side  = f7_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= dv0_in;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_div
      localparam int BIT = QB - 1 - k;
      logic [CMPW-1:0] trial;
      logic [CMPW-1:0] rx;
      logic [CMPW-1:0] ry;
      logic            gx;
      logic            gy;
      div_type         nxt_in;

      always_comb begin
         trial  = CMPW'(dv_ff[k].v) << BIT;
         rx     = CMPW'(dv_ff[k].remx);
         ry     = CMPW'(dv_ff[k].remy);
         gx     = (rx >= trial);
         gy     = (ry >= trial);
         nxt_in = dv_ff[k];
         if (gx) begin
            nxt_in.remx    = NUMW'(rx - trial);
            nxt_in.qx[BIT] = 1'b1;
         end
         if (gy) begin
            nxt_in.remy    = NUMW'(ry - trial);
            nxt_in.qy[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[k+1] <= nxt_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // Center: signed offset, then clamp and distance to second point
   // ---------------------------------------------------------------
   logic signed [FXW-1:0] qsx_in, qsy_in;
   logic signed [FXW-1:0] fx1_ff, fy1_ff;
   logic signed [CW-1:0]  x2t1_ff, y2t1_ff;
   logic                  farx1_ff, fary1_ff, negx1_ff, negy1_ff, coll1_ff;

   always_comb begin
      qsx_in = dv_ff[QB].negx ? -$signed(FXW'(dv_ff[QB].qx)) : $signed(FXW'(dv_ff[QB].qx));
      qsy_in = dv_ff[QB].negy ? -$signed(FXW'(dv_ff[QB].qy)) : $signed(FXW'(dv_ff[QB].qy));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fx1_ff   <= FXW'(dv_ff[QB].side.x1) + qsx_in;
         fy1_ff   <= FXW'(dv_ff[QB].side.y1) + qsy_in;
         x2t1_ff  <= dv_ff[QB].side.x2;
         y2t1_ff  <= dv_ff[QB].side.y2;
         farx1_ff <= dv_ff[QB].farx;
         fary1_ff <= dv_ff[QB].fary;
         negx1_ff <= dv_ff[QB].negx;
         negy1_ff <= dv_ff[QB].negy;
         coll1_ff <= dv_ff[QB].coll;
      end
   end

   logic signed [EW-1:0] ex_in, ey_in;
   logic                 ovx_in, unx_in, ovy_in, uny_in;
   back_type             bk2_in;
   logic [EMW-1:0]       exm2_ff, eym2_ff;
   back_type             bk2_ff;

   always_comb begin
      ex_in  = EW'(x2t1_ff) - EW'(fx1_ff);
      ey_in  = EW'(y2t1_ff) - EW'(fy1_ff);
      ovx_in = (fx1_ff > FX_MAX);
      unx_in = (fx1_ff < FX_MIN);
      ovy_in = (fy1_ff > FX_MAX);
      uny_in = (fy1_ff < FX_MIN);

      // far offset saturates by its sign; otherwise clamp the sum
      if (farx1_ff)    bk2_in.cx = negx1_ff ? C_MIN : C_MAX;
      else if (ovx_in) bk2_in.cx = C_MAX;
      else if (unx_in) bk2_in.cx = C_MIN;
      else             bk2_in.cx = fx1_ff[CW-1:0];

      if (fary1_ff)    bk2_in.cy = negy1_ff ? C_MIN : C_MAX;
      else if (ovy_in) bk2_in.cy = C_MAX;
      else if (uny_in) bk2_in.cy = C_MIN;
      else             bk2_in.cy = fy1_ff[CW-1:0];

      bk2_in.csat = farx1_ff | fary1_ff | ovx_in | unx_in | ovy_in | uny_in;
      bk2_in.near = !(farx1_ff | fary1_ff);
      bk2_in.coll = coll1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         exm2_ff <= ex_in[EW-1] ? EMW'(-ex_in) : EMW'(ex_in);
         eym2_ff <= ey_in[EW-1] ? EMW'(-ey_in) : EMW'(ey_in);
         bk2_ff  <= bk2_in;
      end
   end

   // Squared distance from split partial squares
   logic [2*EHW-1:0]   hhx3_ff, hhy3_ff;
   logic [EHW+ELW-1:0] hlx3_ff, hly3_ff;
   logic [2*ELW-1:0]   llx3_ff, lly3_ff;
   back_type           bk3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         hhx3_ff <= exm2_ff[EMW-1:ELW] * exm2_ff[EMW-1:ELW];
         hlx3_ff <= exm2_ff[EMW-1:ELW] * exm2_ff[ELW-1:0];
         llx3_ff <= exm2_ff[ELW-1:0] * exm2_ff[ELW-1:0];
         hhy3_ff <= eym2_ff[EMW-1:ELW] * eym2_ff[EMW-1:ELW];
         hly3_ff <= eym2_ff[EMW-1:ELW] * eym2_ff[ELW-1:0];
         lly3_ff <= eym2_ff[ELW-1:0] * eym2_ff[ELW-1:0];
         bk3_ff  <= bk2_ff;
      end
   end

   logic [E2W-1:0] ex2_4_ff, ey2_4_ff;
   back_type       bk4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ex2_4_ff <= (E2W'(hhx3_ff) << (2*ELW)) + (E2W'(hlx3_ff) << (ELW+1)) + E2W'(llx3_ff);
         ey2_4_ff <= (E2W'(hhy3_ff) << (2*ELW)) + (E2W'(hly3_ff) << (ELW+1)) + E2W'(lly3_ff);
         bk4_ff   <= bk3_ff;
      end
   end

   logic [SQW-1:0] sum5_ff;
   back_type       bk5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sum5_ff <= SQW'(ex2_4_ff) + SQW'(ey2_4_ff);
         bk5_ff  <= bk4_ff;
      end
   end

   // ---------------------------------------------------------------
   // Square root: range check, then one root bit per stage
   // ---------------------------------------------------------------
   sq_type sq_ff [CW+1];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0].rad  <= sum5_ff[ROOTIN-1:0];
         sq_ff[0].rem  <= '0;
         sq_ff[0].root <= '0;
         sq_ff[0].rsat <= (sum5_ff >= RLIM);
         sq_ff[0].bk   <= bk5_ff;
      end
   end

   for (genvar k = 0; k < CW; k++) begin : g_sqrt
      logic [RRW-1:0] remsh;
      logic [RRW-1:0] trial;
      logic           ge;
      sq_type         nxt_in;

      always_comb begin
         remsh       = {sq_ff[k].rem[RRW-3:0], sq_ff[k].rad[ROOTIN-1-2*k -: 2]};
         trial       = RRW'({sq_ff[k].root, 2'b01});
         ge          = (remsh >= trial);
         nxt_in      = sq_ff[k];
         nxt_in.rem  = ge ? (remsh - trial) : remsh;
         nxt_in.root = {sq_ff[k].root[CW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k+1] <= nxt_in;
         end
      end
   end

   // Final rounding and status
   rsp_type arr_in;
   logic    up_in;

   always_comb begin
      up_in = (sq_ff[CW].rem > RRW'(sq_ff[CW].root));
      if (sq_ff[CW].bk.coll) begin
         arr_in.center_x = '0;
         arr_in.center_y = '0;
         arr_in.radius   = '0;
         arr_in.status   = STATUS_COLLINEAR;
      end else begin
         arr_in.center_x = sq_ff[CW].bk.cx;
         arr_in.center_y = sq_ff[CW].bk.cy;
         if (!sq_ff[CW].bk.near || sq_ff[CW].rsat) arr_in.radius = R_MAX;
         else arr_in.radius = sq_ff[CW].root + CW'(up_in);
         if (!sq_ff[CW].bk.near || sq_ff[CW].rsat || sq_ff[CW].bk.csat) begin
            arr_in.status = STATUS_SATURATED;
         end else begin
            arr_in.status = STATUS_OK;
         end
      end
   end

   // ---------------------------------------------------------------
   // Valid chain, output register and skid
   // ---------------------------------------------------------------
   logic    out_v_ff, skid_v_ff;
   rsp_type out_ff, skid_ff;

   assign en        = !skid_v_ff;
   assign req_ready = en;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff  <= '0;
         dvv_ff <= '0;
         tv_ff  <= '0;
         sqv_ff <= '0;
      end else if (en) begin
         fv_ff  <= {fv_ff[5:0], req_valid};
         dvv_ff <= {dvv_ff[QB-1:0], fv_ff[6]};
         tv_ff  <= {tv_ff[3:0], dvv_ff[QB]};
         sqv_ff <= {sqv_ff[CW-1:0], tv_ff[4]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (rsp_ready || !out_v_ff) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= sqv_ff[CW];
         end
      end else if (sqv_ff[CW]) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !out_v_ff) begin
         out_ff <= skid_v_ff ? skid_ff : arr_in;
      end else if (sqv_ff[CW] && en) begin
         skid_ff <= arr_in;
      end
   end

endmodule

`default_nettype wire
